@@ rtl/cbpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic Bezier point generator package
// Shared widths, reset values and transaction types of the point generator.
// ----------------------------------------------------------------------------
package cbpg_pkg;

  // Coordinate width is fixed by the transaction types below.
  localparam int CBPG_CW    = 32;
  localparam int CBPG_IDX_W = 6;
  localparam int CBPG_REM_W = CBPG_IDX_W + 1;

  localparam logic [CBPG_IDX_W-1:0] CBPG_SEG_RESET = 6'd20;

  // One curve: four control points, x/y/z each.
  typedef struct packed {
    logic signed [CBPG_CW-1:0] p0_x;
    logic signed [CBPG_CW-1:0] p0_y;
    logic signed [CBPG_CW-1:0] p0_z;
    logic signed [CBPG_CW-1:0] p1_x;
    logic signed [CBPG_CW-1:0] p1_y;
    logic signed [CBPG_CW-1:0] p1_z;
    logic signed [CBPG_CW-1:0] p2_x;
    logic signed [CBPG_CW-1:0] p2_y;
    logic signed [CBPG_CW-1:0] p2_z;
    logic signed [CBPG_CW-1:0] p3_x;
    logic signed [CBPG_CW-1:0] p3_y;
    logic signed [CBPG_CW-1:0] p3_z;
  } cbpg_in_t;

  // One evaluated point.
  typedef struct packed {
    logic signed [CBPG_CW-1:0] curve_x;
    logic signed [CBPG_CW-1:0] curve_y;
    logic signed [CBPG_CW-1:0] curve_z;
    logic [CBPG_IDX_W-1:0]     point_index;
    logic                      last_point;
  } cbpg_out_t;

  // Control that travels with each point through the pipeline.
  typedef struct packed {
    logic                  valid;
    logic [CBPG_IDX_W-1:0] idx;
    logic                  last;
  } cbpg_ctl_t;

endpackage

@@ rtl/cbpg_recip.sv @@
// ----------------------------------------------------------------------------
// Step size divider
// Restoring divider that forms floor(2^F / n) and 2^F mod n, one bit a cycle.
// ----------------------------------------------------------------------------
module cbpg_recip
  import cbpg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CBPG_IDX_W-1:0]  den,
  output logic                   busy,
  output logic [FRAC_BITS:0]     quo,
  output logic [CBPG_IDX_W-1:0]  rem
);

  localparam int WW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(WW + 1);

  logic                  run_r, run_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CBPG_REM_W-1:0] rem_r, rem_nxt;
  logic [WW-1:0]         quo_r, quo_nxt;
  logic [CBPG_REM_W-1:0] shifted;
  logic                  qbit;

  // The dividend is a single one in its top bit, so only the first step
  // shifts in a one.
  always_comb begin
    shifted = {rem_r[CBPG_IDX_W-1:0], (cnt_r == '0)};
    qbit    = (shifted >= {1'b0, den});
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = '0;
    end else if (run_r) begin
      rem_nxt = qbit ? (shifted - {1'b0, den}) : shifted;
      quo_nxt = {quo_r[WW-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WW - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = run_r;
  assign quo  = quo_r;
  assign rem  = rem_r[CBPG_IDX_W-1:0];

endmodule

@@ rtl/cbpg_seq.sv @@
// ----------------------------------------------------------------------------
// Point sequencer
// Holds one curve and issues one sample index and its parameter t per cycle.
// ----------------------------------------------------------------------------
module cbpg_seq
  import cbpg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  cbpg_in_t               in_pts,
  input  logic [CBPG_IDX_W-1:0]  n_eff,
  input  logic [FRAC_BITS:0]     step_q,
  input  logic [CBPG_IDX_W-1:0]  step_r,
  output logic                   running,
  output cbpg_ctl_t              out_ctl,
  output logic [FRAC_BITS:0]     out_t,
  output cbpg_in_t               out_pts
);

  localparam int WW = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t            state_r, state_nxt;
  logic [CBPG_IDX_W-1:0] idx_r, idx_nxt;
  logic [CBPG_IDX_W-1:0] n_r, n_nxt;
  logic [WW-1:0]         t_r, t_nxt;
  logic [CBPG_REM_W-1:0] rem_r, rem_nxt;
  cbpg_in_t              pts_r, pts_nxt;
  logic [CBPG_REM_W-1:0] rem_sum;
  logic                  carry;

  // t advances by the integer step plus a carry from the running remainder,
  // which keeps t equal to floor(i * 2^F / n) exactly.
  always_comb begin
    rem_sum   = rem_r + {1'b0, step_r};
    carry     = (rem_sum >= {1'b0, n_r});
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    rem_nxt   = rem_r;
    pts_nxt   = pts_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          idx_nxt   = '0;
          n_nxt     = n_eff;
          t_nxt     = '0;
          rem_nxt   = '0;
          pts_nxt   = in_pts;
        end
      end
      ST_RUN: begin
        if (idx_r == n_r) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rem_nxt = carry ? (rem_sum - {1'b0, n_r}) : rem_sum;
          t_nxt   = t_r + step_q + WW'(carry);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    t_r   <= t_nxt;
    rem_r <= rem_nxt;
    pts_r <= pts_nxt;
  end

  assign running       = (state_r == ST_RUN);
  assign out_ctl.valid = (state_r == ST_RUN);
  assign out_ctl.idx   = idx_r;
  assign out_ctl.last  = (idx_r == n_r);
  assign out_t         = t_r;
  assign out_pts       = pts_r;

endmodule

@@ rtl/cbpg_datapath.sv @@
// ----------------------------------------------------------------------------
// Bernstein evaluation pipeline
// Six register stages from parameter t to one saturated curve point.
// ----------------------------------------------------------------------------
module cbpg_datapath
  import cbpg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cbpg_ctl_t          in_ctl,
  input  logic [FRAC_BITS:0] in_t,
  input  cbpg_in_t           in_pts,
  output logic               out_strobe,
  output cbpg_out_t          out_data
);

  localparam int F   = FRAC_BITS;
  localparam int WW  = F + 1;
  localparam int CW  = CBPG_CW;
  localparam int PW  = CW + WW + 1;
  localparam int SW  = PW + 2;
  localparam int SHW = SW - F;
  localparam logic [WW-1:0] ONE = {1'b1, {F{1'b0}}};

  // Stage 1: squares of t and 1-t.
  cbpg_ctl_t     s1_ctl_r;
  cbpg_in_t      s1_pts_r;
  logic [WW-1:0] s1_t_r, s1_u_r, s1_u2_r, s1_t2_r;
  logic [WW-1:0] u_nxt;
  logic [2*WW-1:0] uu_nxt, tt_nxt;

  always_comb begin
    u_nxt  = ONE - in_t;
    uu_nxt = u_nxt * u_nxt;
    tt_nxt = in_t * in_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= in_ctl;
    end
    s1_pts_r <= in_pts;
    s1_t_r   <= in_t;
    s1_u_r   <= u_nxt;
    s1_u2_r  <= uu_nxt[F +: WW];
    s1_t2_r  <= tt_nxt[F +: WW];
  end

  // Stage 2: the four Bernstein weights.
  cbpg_ctl_t       s2_ctl_r;
  cbpg_in_t        s2_pts_r;
  logic [WW-1:0]   s2_w_r [4];
  logic [WW-1:0]   w_nxt  [4];
  logic [2*WW-1:0] m0, m1, m2, m3;
  logic [WW-1:0]   a1, a2;

  always_comb begin
    m0 = s1_u2_r * s1_u_r;
    m1 = s1_t_r * s1_u2_r;
    m2 = s1_t2_r * s1_u_r;
    m3 = s1_t2_r * s1_t_r;
    a1 = m1[F +: WW];
    a2 = m2[F +: WW];
    w_nxt[0] = m0[F +: WW];
    w_nxt[1] = {a1[WW-2:0], 1'b0} + a1;
    w_nxt[2] = {a2[WW-2:0], 1'b0} + a2;
    w_nxt[3] = m3[F +: WW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s1_ctl_r;
    end
    s2_pts_r <= s1_pts_r;
    for (int k = 0; k < 4; k++) begin
      s2_w_r[k] <= w_nxt[k];
    end
  end

  // Stage 3: twelve coordinate-by-weight products.
  logic signed [CW-1:0] pc [3][4];
  logic signed [WW:0]   ws [4];
  cbpg_ctl_t            s3_ctl_r;
  logic signed [PW-1:0] s3_prod_r [3][4];

  assign pc[0][0] = s2_pts_r.p0_x;
  assign pc[1][0] = s2_pts_r.p0_y;
  assign pc[2][0] = s2_pts_r.p0_z;
  assign pc[0][1] = s2_pts_r.p1_x;
  assign pc[1][1] = s2_pts_r.p1_y;
  assign pc[2][1] = s2_pts_r.p1_z;
  assign pc[0][2] = s2_pts_r.p2_x;
  assign pc[1][2] = s2_pts_r.p2_y;
  assign pc[2][2] = s2_pts_r.p2_z;
  assign pc[0][3] = s2_pts_r.p3_x;
  assign pc[1][3] = s2_pts_r.p3_y;
  assign pc[2][3] = s2_pts_r.p3_z;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ws[k] = $signed({1'b0, s2_w_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else begin
      s3_ctl_r <= s2_ctl_r;
    end
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        s3_prod_r[c][k] <= PW'(pc[c][k]) * PW'(ws[k]);
      end
    end
  end

  // Stage 4: pairwise sums.
  cbpg_ctl_t              s4_ctl_r;
  logic signed [PW:0]     s4_a_r [3];
  logic signed [PW:0]     s4_b_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else begin
      s4_ctl_r <= s3_ctl_r;
    end
    for (int c = 0; c < 3; c++) begin
      s4_a_r[c] <= {s3_prod_r[c][0][PW-1], s3_prod_r[c][0]}
                 + {s3_prod_r[c][1][PW-1], s3_prod_r[c][1]};
      s4_b_r[c] <= {s3_prod_r[c][2][PW-1], s3_prod_r[c][2]}
                 + {s3_prod_r[c][3][PW-1], s3_prod_r[c][3]};
    end
  end

  // Stage 5: full weighted sum per coordinate.
  cbpg_ctl_t            s5_ctl_r;
  logic signed [SW-1:0] s5_sum_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctl_r <= '0;
    end else begin
      s5_ctl_r <= s4_ctl_r;
    end
    for (int c = 0; c < 3; c++) begin
      s5_sum_r[c] <= {s4_a_r[c][PW], s4_a_r[c]} + {s4_b_r[c][PW], s4_b_r[c]};
    end
  end

  // Stage 6: drop the fraction (floor) and saturate into the output register.
  logic signed [SW-1:0]  shf  [3];
  logic signed [CW-1:0]  sat  [3];
  logic                  ovf  [3];
  logic                  strobe_r;
  cbpg_out_t             out_r, out_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shf[c] = s5_sum_r[c] >>> F;
      ovf[c] = (shf[c][SHW-1:CW-1] != '0) && (shf[c][SHW-1:CW-1] != '1);
      if (ovf[c]) begin
        sat[c] = shf[c][SHW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        sat[c] = shf[c][CW-1:0];
      end
    end
    out_nxt.curve_x     = sat[0];
    out_nxt.curve_y     = sat[1];
    out_nxt.curve_z     = sat[2];
    out_nxt.point_index = s5_ctl_r.idx;
    out_nxt.last_point  = s5_ctl_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s5_ctl_r.valid;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

@@ rtl/cubic_bezier_point_generator.sv @@
// ----------------------------------------------------------------------------
// Cubic Bezier point generator
// Evaluates a cubic Bezier curve at segments+1 evenly spaced points.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data with the four control points and raise start. The
//   curve is taken at the rising edge where start is high and busy is low.
//   Output: every point is shown on out_data for one cycle with out_strobe
//   high; the receiver cannot hold points off, so nothing ever stalls.
//   Configuration: cfg_data carries the segment count (0 is taken as 1),
//   written when cfg_valid and cfg_ready are both high, only while idle and
//   never in a cycle where start is high.
// Timing:
//   A curve with n segments gives n+1 points, one per cycle, from a
//   six-stage evaluation pipeline. busy is high while the points are
//   issued and low when the next curve is taken. The next curve does not
//   wait for the pipeline to drain.
// Reset and reconfiguration:
//   Reset sets the segment count to 20. After reset and after each
//   configuration write, a bit-serial divider forms the step of t; busy
//   and not cfg_ready are shown meanwhile.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator
  import cbpg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  cbpg_in_t              in_data,
  output logic                  out_strobe,
  output cbpg_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CBPG_IDX_W-1:0] cfg_data
);

  logic [CBPG_IDX_W-1:0] seg_r, seg_nxt;
  logic                  kick_r, kick_nxt;
  logic [CBPG_IDX_W-1:0] n_eff;
  logic                  cfg_write;
  logic                  accept;
  logic                  div_busy;
  logic                  running;
  logic [FRAC_BITS:0]    step_q;
  logic [CBPG_IDX_W-1:0] step_r;
  cbpg_ctl_t             seq_ctl;
  logic [FRAC_BITS:0]    seq_t;
  cbpg_in_t              seq_pts;

  // Segment register; a write restarts the step divider. A curve offered in
  // the same cycle wins over a configuration write.
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_ready = !busy && !start;

  always_comb begin
    seg_nxt  = cfg_write ? cfg_data : seg_r;
    kick_nxt = cfg_write;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= CBPG_SEG_RESET;
      kick_r <= 1'b1;
    end else begin
      seg_r  <= seg_nxt;
      kick_r <= kick_nxt;
    end
  end

  assign n_eff  = (seg_r == '0) ? CBPG_IDX_W'(1) : seg_r;
  assign busy   = running || div_busy || kick_r;
  assign accept = start && !busy;

  cbpg_recip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kick_r),
    .den   (n_eff),
    .busy  (div_busy),
    .quo   (step_q),
    .rem   (step_r)
  );

  cbpg_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_pts  (in_data),
    .n_eff   (n_eff),
    .step_q  (step_q),
    .step_r  (step_r),
    .running (running),
    .out_ctl (seq_ctl),
    .out_t   (seq_t),
    .out_pts (seq_pts)
  );

  cbpg_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (seq_ctl),
    .in_t       (seq_t),
    .in_pts     (seq_pts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

`ifndef SYNTH
  // An accepted curve keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after a curve transaction");

  // A configuration write blocks new curves while the step is recomputed.
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write |=> busy)
    else $error("busy not raised after a configuration transaction");

  // Points of one curve leave back to back.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last_point) |=> out_strobe)
    else $error("gap inside a curve");

  // The sample index climbs by one within a curve.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last_point) |=>
      (out_data.point_index == $past(out_data.point_index) + 1'b1))
    else $error("point index out of sequence");
`endif

endmodule
